// ----- rtl/shs_pkg.sv -----
// Shared types, constants and round functions for the SHA-256 stream hasher.
package shs_pkg;

    typedef logic [31:0] word_t;

    typedef struct packed {
        word_t a;
        word_t b;
        word_t c;
        word_t d;
        word_t e;
        word_t f;
        word_t g;
        word_t h;
    } work_t;

    localparam word_t INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [7:0] PAD_MARK = 8'h80;

    localparam logic [5:0] FILL_LAST = 6'd63;
    localparam logic [5:0] FILL_LEN  = 6'd56;

    function automatic word_t rotr(input word_t x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic word_t big_sigma0(input word_t x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic word_t big_sigma1(input word_t x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic word_t small_sigma0(input word_t x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic word_t small_sigma1(input word_t x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic word_t round_k(input logic [5:0] idx);
        word_t k;
        unique case (idx)
            6'd0:  k = 32'h428a2f98;
            6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;
            6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;
            6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;
            6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;
            6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;
            6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;
            6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;
            6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;
            6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;
            6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;
            6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;
            6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;
            6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;
            6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;
            6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;
            6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;
            6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;
            6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;
            6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;
            6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;
            6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;
            6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;
            6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;
            6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;
            6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;
            6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;
            6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;
            6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;
            6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;
            6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;
            6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;
            6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

endpackage

// ----- rtl/sha256_stream_hasher_unit.sv -----
// Top level of the SHA-256 stream hasher: byte collection, padding and round sequencer.
//
// Input channel s_*: one item per message byte (s_tuser = 0, byte in s_tdata) or a
// finish item (s_tuser = 1) that closes the message.
// Output channel m_*: eight digest words per finish, most significant first;
// m_tuser carries the word index and m_tlast marks the eighth word.
// Data bytes are taken one per cycle while s_tready is high; the 64th byte
// of a block starts a compression (load, 64 rounds of the shared round unit,
// chain add) before the next byte is taken.
// A finish shifts in padding and the length one byte per cycle (up to 64
// bytes, or 72 with an extra block; nothing is shifted as the zero fill
// gives way to the length) plus one or two compressions, then presents the
// digest words one per cycle while m_tready is high.
// s_tready is low from the end of a block until its compression completes,
// and from a finish until the last digest word is taken.
// A stalled receiver holds the current digest word on m_tdata; nothing else
// advances meanwhile.
// Reset loads the initial hash and clears the bit count and fill level; the
// same state returns after every digest, ready for the next message.
module sha256_stream_hasher_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] digest_word
    output logic [2:0]  m_tuser,   // [2:0] word_index
    output logic        m_tlast    // last_word
);
    import shs_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PADZ = 3'd1;
    localparam logic [2:0] S_PADL = 3'd2;
    localparam logic [2:0] S_LOAD = 3'd3;
    localparam logic [2:0] S_COMP = 3'd4;
    localparam logic [2:0] S_ADD  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0]  state_reg;
    logic [2:0]  state_next;
    logic [2:0]  after_reg;
    logic [5:0]  fill_reg;
    logic [63:0] bits_reg;
    logic [5:0]  rnd_reg;
    logic [2:0]  out_idx_reg;
    word_t       chain_reg [8];
    word_t       w_reg [16];
    work_t       work_reg;
    work_t       work_nxt;
    word_t       w_new;

    logic        shift_en;
    logic [7:0]  shift_byte;

    shs_round u_round (
        .rnd   (rnd_reg),
        .cur   (work_reg),
        .w0    (w_reg[0]),
        .w1    (w_reg[1]),
        .w9    (w_reg[9]),
        .w14   (w_reg[14]),
        .nxt   (work_nxt),
        .w_new (w_new)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata  = chain_reg[out_idx_reg];
    assign m_tuser  = out_idx_reg;
    assign m_tlast  = (out_idx_reg == 3'd7);

    always_comb
    begin
        shift_en   = 1'b0;
        shift_byte = 8'h00;
        unique case (state_reg)
            S_IDLE:
            begin
                shift_en   = s_tvalid;
                shift_byte = s_tuser ? PAD_MARK : s_tdata;
            end
            S_PADZ:
            begin
                shift_en = (fill_reg != FILL_LEN);
            end
            S_PADL:
            begin
                shift_en   = 1'b1;
                shift_byte = bits_reg[63:56];
            end
            default:
            begin
                shift_en = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (fill_reg == FILL_LAST)
                        state_next = S_LOAD;
                    else if (s_tuser)
                        state_next = S_PADZ;
                end
            end
            S_PADZ:
            begin
                if (fill_reg == FILL_LEN)
                    state_next = S_PADL;
                else if (fill_reg == FILL_LAST)
                    state_next = S_LOAD;
            end
            S_PADL:
            begin
                if (fill_reg == FILL_LAST)
                    state_next = S_LOAD;
            end
            S_LOAD:
            begin
                state_next = S_COMP;
            end
            S_COMP:
            begin
                if (rnd_reg == 6'd63)
                    state_next = S_ADD;
            end
            S_ADD:
            begin
                state_next = after_reg;
            end
            S_OUT:
            begin
                if (m_tready && (out_idx_reg == 3'd7))
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            after_reg   <= S_IDLE;
            fill_reg    <= '0;
            bits_reg    <= '0;
            rnd_reg     <= '0;
            out_idx_reg <= '0;
            for (int i = 0; i < 8; i++)
                chain_reg[i] <= INIT_HASH[i];
        end
        else
        begin
            state_reg <= state_next;
            if (shift_en)
                fill_reg <= fill_reg + 6'd1;
            if ((state_next == S_LOAD) && (state_reg != S_LOAD))
            begin
                if (state_reg == S_PADL)
                    after_reg <= S_OUT;
                else if ((state_reg == S_IDLE) && !s_tuser)
                    after_reg <= S_IDLE;
                else
                    after_reg <= S_PADZ;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid && !s_tuser)
                        bits_reg <= bits_reg + 64'd8;
                end
                S_PADL:
                begin
                    bits_reg <= {bits_reg[55:0], 8'h00};
                end
                S_LOAD:
                begin
                    rnd_reg <= '0;
                end
                S_COMP:
                begin
                    rnd_reg <= rnd_reg + 6'd1;
                end
                S_ADD:
                begin
                    chain_reg[0] <= chain_reg[0] + work_reg.a;
                    chain_reg[1] <= chain_reg[1] + work_reg.b;
                    chain_reg[2] <= chain_reg[2] + work_reg.c;
                    chain_reg[3] <= chain_reg[3] + work_reg.d;
                    chain_reg[4] <= chain_reg[4] + work_reg.e;
                    chain_reg[5] <= chain_reg[5] + work_reg.f;
                    chain_reg[6] <= chain_reg[6] + work_reg.g;
                    chain_reg[7] <= chain_reg[7] + work_reg.h;
                end
                S_OUT:
                begin
                    if (m_tready)
                    begin
                        out_idx_reg <= out_idx_reg + 3'd1;
                        if (out_idx_reg == 3'd7)
                        begin
                            for (int i = 0; i < 8; i++)
                                chain_reg[i] <= INIT_HASH[i];
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_LOAD)
        begin
            work_reg.a <= chain_reg[0];
            work_reg.b <= chain_reg[1];
            work_reg.c <= chain_reg[2];
            work_reg.d <= chain_reg[3];
            work_reg.e <= chain_reg[4];
            work_reg.f <= chain_reg[5];
            work_reg.g <= chain_reg[6];
            work_reg.h <= chain_reg[7];
        end
        else if (state_reg == S_COMP)
        begin
            work_reg <= work_nxt;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            for (int i = 0; i < 15; i++)
                w_reg[i] <= {w_reg[i][23:0], w_reg[i + 1][31:24]};
            w_reg[15] <= {w_reg[15][23:0], shift_byte};
        end
        else if (state_reg == S_COMP)
        begin
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i + 1];
            w_reg[15] <= w_new;
        end
    end

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input accepted while digest pending");

    a_fill_track: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (fill_reg == bits_reg[8:3]))
        else $error("fill level out of step with bit count");

    a_finish_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser) |=> !s_tready)
        else $error("ready after finish item");

    a_ready_after_digest: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast) |=> (s_tready && (bits_reg == 64'd0)))
        else $error("not restarted after last digest word");

endmodule

// ----- rtl/shs_round.sv -----
// One SHA-256 compression round and one message schedule step.
module shs_round (
    input  logic [5:0]      rnd,
    input  shs_pkg::work_t  cur,
    input  shs_pkg::word_t  w0,
    input  shs_pkg::word_t  w1,
    input  shs_pkg::word_t  w9,
    input  shs_pkg::word_t  w14,
    output shs_pkg::work_t  nxt,
    output shs_pkg::word_t  w_new
);
    import shs_pkg::*;

    word_t t1;
    word_t t2;
    word_t ch;
    word_t maj;

    assign ch    = (cur.e & cur.f) ^ (~cur.e & cur.g);
    assign maj   = (cur.a & cur.b) ^ (cur.a & cur.c) ^ (cur.b & cur.c);
    assign t1    = cur.h + big_sigma1(cur.e) + ch + round_k(rnd) + w0;
    assign t2    = big_sigma0(cur.a) + maj;
    assign w_new = small_sigma1(w14) + w9 + small_sigma0(w1) + w0;

    always_comb
    begin
        nxt.h = cur.g;
        nxt.g = cur.f;
        nxt.f = cur.e;
        nxt.e = cur.d + t1;
        nxt.d = cur.c;
        nxt.c = cur.b;
        nxt.b = cur.a;
        nxt.a = t1 + t2;
    end

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the SHA-256 stream hasher: directed and random messages against a digest predictor.
`timescale 1ns / 1ps

module tb_top;

    import shs_pkg::word_t;

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_FINISH = 1'b1;

    localparam int RANDOM_ITEMS = 450;
    localparam int MIN_MESSAGES = 8;
    localparam int IDLE_LIMIT   = 4000;
    localparam int TAIL_CYCLES  = 300;

    localparam word_t START_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam word_t ROUND_CONST [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam int BOUNDARY_LEN [12] = '{54, 55, 56, 57, 62, 63, 64, 65, 119, 120, 127, 128};

    typedef struct packed {
        word_t      word;
        logic [2:0] index;
        logic       last;
    } digest_word_t;

    class digest_scoreboard;
        word_t          chain [8];
        logic [7:0]     msg_block [64];
        logic [63:0]    bit_count;
        digest_word_t   expected_words [$];
        int             errors;
        int             words_checked;
        int             digests_noted;

        function new();
            errors = 0;
            words_checked = 0;
            digests_noted = 0;
            restart();
        endfunction

        function void restart();
            foreach (chain[i])
                chain[i] = START_HASH[i];
            foreach (msg_block[i])
                msg_block[i] = 8'h00;
            bit_count = 64'd0;
        endfunction

        function word_t ror(input word_t x, input int n);
            logic [63:0] twice;
            twice = {x, x} >> n;
            return twice[31:0];
        endfunction

        function void compress();
            word_t w [64];
            word_t v [8];
            word_t s0, s1, t1, t2, e, a;
            for (int i = 0; i < 16; i++)
                w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
            for (int i = 16; i < 64; i++)
            begin
                s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
                s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
                w[i] = s1 + w[i-7] + s0 + w[i-16];
            end
            foreach (v[i])
                v[i] = chain[i];
            for (int i = 0; i < 64; i++)
            begin
                e = v[4];
                a = v[0];
                t1 = v[7] + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & v[5]) ^ (~e & v[6]))
                     + ROUND_CONST[i] + w[i];
                t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & v[1]) ^ (a & v[2]) ^ (v[1] & v[2]));
                v[7] = v[6];
                v[6] = v[5];
                v[5] = v[4];
                v[4] = v[3] + t1;
                v[3] = v[2];
                v[2] = v[1];
                v[1] = v[0];
                v[0] = t1 + t2;
            end
            foreach (chain[i])
                chain[i] = chain[i] + v[i];
        endfunction

        function void note_item(input logic kind, input logic [7:0] data_val);
            logic [5:0]   fill;
            int           pos;
            digest_word_t dw;
            fill = bit_count[8:3];
            if (kind == KIND_DATA)
            begin
                msg_block[fill] = data_val;
                bit_count = bit_count + 64'd8;
                if (fill == 6'd63)
                    compress();
            end
            else
            begin
                msg_block[fill] = 8'h80;
                pos = int'(fill) + 1;
                if (pos > 56)
                begin
                    for (int j = pos; j < 64; j++)
                        msg_block[j] = 8'h00;
                    compress();
                    pos = 0;
                end
                for (int j = pos; j < 56; j++)
                    msg_block[j] = 8'h00;
                for (int j = 0; j < 8; j++)
                    msg_block[56+j] = bit_count[63-8*j -: 8];
                compress();
                for (int j = 0; j < 8; j++)
                begin
                    dw.word  = chain[j];
                    dw.index = 3'(j);
                    dw.last  = (j == 7);
                    expected_words.push_back(dw);
                end
                digests_noted++;
                restart();
            end
        endfunction

        function void check_word(input word_t word, input logic [2:0] index, input logic last);
            digest_word_t dw;
            if (expected_words.size() == 0)
            begin
                $display("%0t unexpected digest word %h index %0d last %0b", $time, word, index, last);
                errors++;
                return;
            end
            dw = expected_words.pop_front();
            words_checked++;
            if (word !== dw.word)
            begin
                $display("%0t digest_word mismatch: expected %h, actual %h", $time, dw.word, word);
                errors++;
            end
            if (index !== dw.index)
            begin
                $display("%0t word_index mismatch: expected %0d, actual %0d", $time, dw.index, index);
                errors++;
            end
            if (last !== dw.last)
            begin
                $display("%0t last_word mismatch: expected %0b, actual %0b", $time, dw.last, last);
                errors++;
            end
        endfunction

        function int pending();
            return expected_words.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    digest_scoreboard sb = new();

    bit no_gaps = 1'b0;
    int items_sent = 0;
    int bytes_sent = 0;
    int longest_msg = 0;
    int idle_cycles = 0;

    sha256_stream_hasher_unit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return $urandom_range(0, 12);
        if (r < 75)
            return BOUNDARY_LEN[$urandom_range(0, 11)];
        if (r < 95)
            return $urandom_range(13, 70);
        return $urandom_range(100, 200);
    endfunction

    task automatic send_item(input logic kind, input logic [7:0] val);
        int gap;
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= val;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_item(kind, val);
        items_sent++;
        if (kind == KIND_DATA)
            bytes_sent++;
    endtask

    task automatic send_message(input int len);
        for (int i = 0; i < len; i++)
            send_item(KIND_DATA, 8'($urandom_range(0, 255)));
        send_item(KIND_FINISH, 8'($urandom_range(0, 255)));
        if (len > longest_msg)
            longest_msg = len;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // receiver: random stalls, no new stall starts while a burst phase runs
    initial
    begin
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_tready <= 1'b1;
                if (!no_gaps && $urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_word(m_tdata, m_tuser, m_tlast);
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t no handshake for %0d cycles", $time, IDLE_LIMIT);
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        int len;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty messages, the message abc, short messages including the byte extremes
        send_item(KIND_FINISH, 8'h00);
        send_item(KIND_DATA, 8'h61);
        send_item(KIND_DATA, 8'h62);
        send_item(KIND_DATA, 8'h63);
        send_item(KIND_FINISH, 8'hff);
        send_item(KIND_DATA, 8'h00);
        send_item(KIND_FINISH, 8'h00);
        send_item(KIND_DATA, 8'hff);
        send_item(KIND_FINISH, 8'hff);
        send_item(KIND_DATA, 8'h55);
        send_item(KIND_DATA, 8'haa);
        send_item(KIND_FINISH, 8'h5a);
        send_item(KIND_FINISH, 8'ha5);
        drain_results();

        items_sent = 0;
        while (items_sent < RANDOM_ITEMS || sb.digests_noted < MIN_MESSAGES)
        begin
            no_gaps = ($urandom_range(0, 3) == 0);
            len = pick_length();
            send_message(len);
            if ($urandom_range(0, 4) == 0)
                drain_results();
        end
        no_gaps = 1'b0;

        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (sb.pending() != 0)
        begin
            $display("%0t %0d digest words never arrived", $time, sb.pending());
            sb.errors++;
        end

        $display("run covered %0d digests over %0d message bytes, longest message %0d bytes",
                 sb.digests_noted, bytes_sent, longest_msg);
        $display("%0d digest words compared, %0d errors", sb.words_checked, sb.errors);
        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
